// ===== rtl/core/rfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_pkg: shared types and constants of the rational fraction ALU
// Request and result structs, opcode and verdict codes, datapath widths.
// ----------------------------------------------------------------------------
package rfa_pkg;

    // Width of one operand; each operand is the low OPERAND_BITS of its field.
    localparam int OPERAND_BITS = 16;
    localparam int FIELD_W      = 16;
    localparam int MUL_W        = OPERAND_BITS + 1;     // signed multiplier operand
    localparam int PROD_W       = 2 * MUL_W;            // signed product
    localparam int SH_W         = $clog2(OPERAND_BITS); // divider shift count
    localparam int NUM_W        = 33;
    localparam int DEN_W        = 32;

    localparam logic [2:0] CMD_MUL  = 3'd0;
    localparam logic [2:0] CMD_DIV  = 3'd1;
    localparam logic [2:0] CMD_ADD  = 3'd2;
    localparam logic [2:0] CMD_SUB  = 3'd3;
    localparam logic [2:0] CMD_CMP  = 3'd4;
    localparam logic [2:0] CMD_INV  = 3'd5;
    localparam logic [2:0] CMD_CLS  = 3'd6;
    localparam logic [2:0] CMD_RSVD = 3'd7;

    localparam logic [1:0] VERD_FIRST    = 2'd0;
    localparam logic [1:0] VERD_SECOND   = 2'd1;
    localparam logic [1:0] VERD_EQUAL    = 2'd2;
    localparam logic [1:0] VERD_PROPER   = 2'd0;
    localparam logic [1:0] VERD_IMPROPER = 2'd1;
    localparam logic [1:0] VERD_NONE     = 2'd0;

    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    typedef struct packed {
        logic [2:0]                cmd;
        logic signed [FIELD_W-1:0] num_a;
        logic signed [FIELD_W-1:0] den_a;
        logic signed [FIELD_W-1:0] num_b;
        logic signed [FIELD_W-1:0] den_b;
    } t_req;

    typedef struct packed {
        logic signed [NUM_W-1:0] result_num;
        logic signed [DEN_W-1:0] result_den;
        logic [1:0]              verdict;
        logic                    status;
    } t_rsp;

endpackage

// ===== rtl/core/rational_fraction_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_fraction_alu: multi-cycle ALU on two signed integer fractions
// Multiply, divide, add, subtract, compare, invert and classify, unreduced.
// ----------------------------------------------------------------------------
// Takes one request at a time (o_req_ready is high only while the sequencer
// is idle) and gives exactly one result per request through a result
// register, so a finished result may wait for i_res_ready while the next
// request is already accepted. Multiply, divide and compare make two passes
// through the one shared signed multiplier, then form the result. Invert,
// classify, error cases and add/subtract with equal denominators go straight
// to the result. Add/subtract with unequal denominators runs Euclid's GCD on
// the denominator magnitudes through one shared shift-subtract divider, then
// two exact quotient divisions by the GCD, then three multiplier passes; the
// divider aligns the divisor, then restore-subtracts one quotient bit at a
// time. The GCD sign follows the truncating remainder: it is the sign of
// whichever denominator the final nonzero remainder descends from.
// ----------------------------------------------------------------------------
module rational_fraction_alu (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  rfa_pkg::t_req i_req,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output rfa_pkg::t_rsp o_res
);

    localparam int W  = rfa_pkg::OPERAND_BITS;
    localparam int MB = rfa_pkg::MUL_W;
    localparam int PW = rfa_pkg::PROD_W;
    localparam int SW = rfa_pkg::SH_W;
    localparam int NW = rfa_pkg::NUM_W;
    localparam int DW = rfa_pkg::DEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_QUO2,
        S_QUO1,
        S_MUL,
        S_DONE
    } t_state;

    // Magnitude of a W-bit two's complement value; the most negative
    // value maps to 2**(W-1), which still fits W unsigned bits.
    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        logic signed [W-1:0] neg;
        neg = -v;
        mag = v[W-1] ? W'(neg) : W'(v);
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state               r_state,   n_state;
    logic [2:0]           r_cmd,     n_cmd;
    logic signed [W-1:0]  r_x1,      n_x1;
    logic signed [W-1:0]  r_y1,      n_y1;
    logic signed [W-1:0]  r_x2,      n_x2;
    logic signed [W-1:0]  r_y2,      n_y2;
    logic                 r_err,     n_err;
    logic                 r_eqden,   n_eqden;
    // shared shift-subtract divider
    logic [W-1:0]         r_dv_rem,  n_dv_rem;
    logic [W-1:0]         r_dv_dvs,  n_dv_dvs;
    logic [W-1:0]         r_dv_quo,  n_dv_quo;
    logic [SW-1:0]        r_dv_sh,   n_dv_sh;
    logic                 r_dv_aln,  n_dv_aln;
    // Euclid bookkeeping: current divisor magnitude and which operand it
    // descends from (0: den_a, 1: den_b)
    logic [W-1:0]         r_gb,      n_gb;
    logic                 r_par,     n_par;
    logic                 r_gneg,    n_gneg;
    logic signed [MB-1:0] r_q1,      n_q1;
    logic signed [MB-1:0] r_q2,      n_q2;
    // shared multiplier and product slots
    logic [1:0]           r_pidx,    n_pidx;
    logic signed [PW-1:0] r_prod,    n_prod;
    logic signed [PW-1:0] r_p0,      n_p0;
    logic signed [PW-1:0] r_p1,      n_p1;
    logic signed [PW-1:0] r_p2,      n_p2;
    rfa_pkg::t_rsp        r_res,     n_res;
    logic                 r_res_valid, n_res_valid;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic signed [W-1:0] in_x1, in_y1, in_x2, in_y2;
    logic                in_err;
    logic                req_acc;

    assign in_x1 = i_req.num_a[W-1:0];
    assign in_y1 = i_req.den_a[W-1:0];
    assign in_x2 = i_req.num_b[W-1:0];
    assign in_y2 = i_req.den_b[W-1:0];

    // zero denominator, division by a zero fraction, or inverting zero
    assign in_err = (i_req.cmd != rfa_pkg::CMD_RSVD) &&
                    ((in_y1 == '0) ||
                     ((i_req.cmd <= rfa_pkg::CMD_CMP) && (in_y2 == '0)) ||
                     ((i_req.cmd == rfa_pkg::CMD_DIV) && (in_x2 == '0)) ||
                     ((i_req.cmd == rfa_pkg::CMD_INV) && (in_x1 == '0)));

    assign o_req_ready = (r_state == S_IDLE);
    assign req_acc     = i_req_valid && o_req_ready;

    // ------------------------------------------------------------------
    // Shared divider step: first align the divisor under the dividend one
    // bit a cycle, then restore-subtract one quotient bit a cycle.
    // ------------------------------------------------------------------
    logic [W:0]   dv_dvs2;
    logic         dv_can_shift;
    logic         dv_ge;
    logic [W-1:0] dv_rem_nx;
    logic [W-1:0] dv_quo_nx;
    logic         dv_done;

    assign dv_dvs2      = {r_dv_dvs, 1'b0};
    assign dv_can_shift = dv_dvs2 <= {1'b0, r_dv_rem};
    assign dv_ge        = r_dv_rem >= r_dv_dvs;
    assign dv_rem_nx    = dv_ge ? (r_dv_rem - r_dv_dvs) : r_dv_rem;
    assign dv_quo_nx    = {r_dv_quo[W-2:0], dv_ge};
    assign dv_done      = !r_dv_aln && (r_dv_sh == '0);

    // the quotient and its negation, for the two divisions by the GCD
    logic signed [MB-1:0] quo_pos;
    logic signed [MB-1:0] quo_neg;

    assign quo_pos = $signed({1'b0, dv_quo_nx});
    assign quo_neg = -quo_pos;

    // ------------------------------------------------------------------
    // Shared multiplier operand select
    // ------------------------------------------------------------------
    logic signed [MB-1:0] mul_a, mul_b;
    logic [1:0]           mul_cnt;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_cmd)
            rfa_pkg::CMD_MUL: begin
                mul_a = (r_pidx == 2'd0) ? MB'(r_x1) : MB'(r_y1);
                mul_b = (r_pidx == 2'd0) ? MB'(r_x2) : MB'(r_y2);
            end
            rfa_pkg::CMD_DIV: begin
                mul_a = (r_pidx == 2'd0) ? MB'(r_x1) : MB'(r_y1);
                mul_b = (r_pidx == 2'd0) ? MB'(r_y2) : MB'(r_x2);
            end
            rfa_pkg::CMD_CMP: begin
                mul_a = (r_pidx == 2'd0) ? MB'(r_x1) : MB'(r_x2);
                mul_b = (r_pidx == 2'd0) ? MB'(r_y2) : MB'(r_y1);
            end
            rfa_pkg::CMD_ADD, rfa_pkg::CMD_SUB: begin
                // common denominator, then both scaled numerators
                unique case (r_pidx)
                    2'd0: begin
                        mul_a = MB'(r_y1);
                        mul_b = r_q2;
                    end
                    2'd1: begin
                        mul_a = MB'(r_x1);
                        mul_b = r_q2;
                    end
                    default: begin
                        mul_a = MB'(r_x2);
                        mul_b = r_q1;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_cnt = ((r_cmd == rfa_pkg::CMD_ADD) || (r_cmd == rfa_pkg::CMD_SUB))
                     ? 2'd3 : 2'd2;
    assign n_prod  = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Result formation
    // ------------------------------------------------------------------
    rfa_pkg::t_rsp res_nx;
    logic          cmp_flip;
    logic          cmp_first;
    logic          cmp_second;

    assign cmp_flip   = r_y1[W-1] ^ r_y2[W-1];
    assign cmp_first  = cmp_flip ? (r_p0 < r_p1) : (r_p0 > r_p1);
    assign cmp_second = cmp_flip ? (r_p1 < r_p0) : (r_p1 > r_p0);

    always_comb begin
        res_nx = '0;
        if (r_err) begin
            res_nx.status = rfa_pkg::STAT_ERR;
        end else begin
            unique case (r_cmd)
                rfa_pkg::CMD_MUL, rfa_pkg::CMD_DIV: begin
                    res_nx.result_num = NW'(r_p0);
                    res_nx.result_den = DW'(r_p1);
                end
                rfa_pkg::CMD_ADD: begin
                    if (r_eqden) begin
                        res_nx.result_num = NW'(r_x1) + NW'(r_x2);
                        res_nx.result_den = DW'(r_y1);
                    end else begin
                        res_nx.result_num = NW'(r_p1) + NW'(r_p2);
                        res_nx.result_den = DW'(r_p0);
                    end
                end
                rfa_pkg::CMD_SUB: begin
                    if (r_eqden) begin
                        res_nx.result_num = NW'(r_x1) - NW'(r_x2);
                        res_nx.result_den = DW'(r_y1);
                    end else begin
                        res_nx.result_num = NW'(r_p1) - NW'(r_p2);
                        res_nx.result_den = DW'(r_p0);
                    end
                end
                rfa_pkg::CMD_CMP: begin
                    // ties report the first fraction
                    if (!cmp_first && cmp_second) begin
                        res_nx.result_num = NW'(r_x2);
                        res_nx.result_den = DW'(r_y2);
                        res_nx.verdict    = rfa_pkg::VERD_SECOND;
                    end else begin
                        res_nx.result_num = NW'(r_x1);
                        res_nx.result_den = DW'(r_y1);
                        res_nx.verdict    = cmp_first ? rfa_pkg::VERD_FIRST
                                                      : rfa_pkg::VERD_EQUAL;
                    end
                end
                rfa_pkg::CMD_INV: begin
                    res_nx.result_num = NW'(r_y1);
                    res_nx.result_den = DW'(r_x1);
                end
                rfa_pkg::CMD_CLS: begin
                    res_nx.verdict = (mag(r_x1) < mag(r_y1)) ? rfa_pkg::VERD_PROPER
                                                             : rfa_pkg::VERD_IMPROPER;
                end
                default: begin
                    res_nx.verdict = rfa_pkg::VERD_NONE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_x2        = r_x2;
        n_y2        = r_y2;
        n_err       = r_err;
        n_eqden     = r_eqden;
        n_dv_rem    = r_dv_rem;
        n_dv_dvs    = r_dv_dvs;
        n_dv_quo    = r_dv_quo;
        n_dv_sh     = r_dv_sh;
        n_dv_aln    = r_dv_aln;
        n_gb        = r_gb;
        n_par       = r_par;
        n_gneg      = r_gneg;
        n_q1        = r_q1;
        n_q2        = r_q2;
        n_pidx      = r_pidx;
        n_p0        = r_p0;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_res_ready;

        // advance the divider whenever it runs
        if ((r_state == S_GCD) || (r_state == S_QUO2) || (r_state == S_QUO1)) begin
            if (r_dv_aln) begin
                if (dv_can_shift) begin
                    n_dv_dvs = dv_dvs2[W-1:0];
                    n_dv_sh  = r_dv_sh + SW'(1);
                end else begin
                    n_dv_aln = 1'b0;
                end
            end else begin
                n_dv_rem = dv_rem_nx;
                n_dv_quo = dv_quo_nx;
                n_dv_dvs = r_dv_dvs >> 1;
                n_dv_sh  = r_dv_sh - SW'(1);
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_cmd   = i_req.cmd;
                    n_x1    = in_x1;
                    n_y1    = in_y1;
                    n_x2    = in_x2;
                    n_y2    = in_y2;
                    n_err   = in_err;
                    n_eqden = (in_y1 == in_y2);
                    n_pidx  = 2'd0;
                    priority if (in_err) begin
                        n_state = S_DONE;
                    end else if ((i_req.cmd == rfa_pkg::CMD_MUL) ||
                                 (i_req.cmd == rfa_pkg::CMD_DIV) ||
                                 (i_req.cmd == rfa_pkg::CMD_CMP)) begin
                        n_state = S_MUL;
                    end else if (((i_req.cmd == rfa_pkg::CMD_ADD) ||
                                  (i_req.cmd == rfa_pkg::CMD_SUB)) &&
                                 (in_y1 != in_y2)) begin
                        // first Euclid step: |den_a| mod |den_b|
                        n_state  = S_GCD;
                        n_dv_rem = mag(in_y1);
                        n_dv_dvs = mag(in_y2);
                        n_dv_quo = '0;
                        n_dv_sh  = '0;
                        n_dv_aln = 1'b1;
                        n_gb     = mag(in_y2);
                        n_par    = 1'b1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_GCD: begin
                if (dv_done) begin
                    if (dv_rem_nx == '0) begin
                        // r_gb is the GCD magnitude; its sign is that of the
                        // denominator it descends from
                        n_gneg   = r_par ? r_y2[W-1] : r_y1[W-1];
                        n_state  = S_QUO2;
                        n_dv_rem = mag(r_y2);
                        n_dv_dvs = r_gb;
                    end else begin
                        n_gb     = dv_rem_nx;
                        n_par    = ~r_par;
                        n_dv_rem = r_gb;
                        n_dv_dvs = dv_rem_nx;
                    end
                    n_dv_quo = '0;
                    n_dv_sh  = '0;
                    n_dv_aln = 1'b1;
                end
            end
            S_QUO2: begin
                if (dv_done) begin
                    n_q2     = (r_y2[W-1] ^ r_gneg) ? quo_neg : quo_pos;
                    n_state  = S_QUO1;
                    n_dv_rem = mag(r_y1);
                    n_dv_dvs = r_gb;
                    n_dv_quo = '0;
                    n_dv_sh  = '0;
                    n_dv_aln = 1'b1;
                end
            end
            S_QUO1: begin
                if (dv_done) begin
                    n_q1    = (r_y1[W-1] ^ r_gneg) ? quo_neg : quo_pos;
                    n_state = S_MUL;
                    n_pidx  = 2'd0;
                end
            end
            S_MUL: begin
                // the product of the previous pass lands in its slot
                unique case (r_pidx)
                    2'd1:    n_p0 = r_prod;
                    2'd2:    n_p1 = r_prod;
                    2'd3:    n_p2 = r_prod;
                    default: n_p0 = r_p0;
                endcase
                if (r_pidx == mul_cnt) begin
                    n_state = S_DONE;
                end else begin
                    n_pidx = r_pidx + 2'd1;
                end
            end
            S_DONE: begin
                // hold until the result register is free
                if (!r_res_valid || i_res_ready) begin
                    n_res       = res_nx;
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
        r_cmd    <= n_cmd;
        r_x1     <= n_x1;
        r_y1     <= n_y1;
        r_x2     <= n_x2;
        r_y2     <= n_y2;
        r_err    <= n_err;
        r_eqden  <= n_eqden;
        r_dv_rem <= n_dv_rem;
        r_dv_dvs <= n_dv_dvs;
        r_dv_quo <= n_dv_quo;
        r_dv_sh  <= n_dv_sh;
        r_dv_aln <= n_dv_aln;
        r_gb     <= n_gb;
        r_par    <= n_par;
        r_gneg   <= n_gneg;
        r_q1     <= n_q1;
        r_q2     <= n_q2;
        r_pidx   <= n_pidx;
        r_prod   <= n_prod;
        r_p0     <= n_p0;
        r_p1     <= n_p1;
        r_p2     <= n_p2;
        r_res    <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ===== rtl/core/rfa_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_check: port-level checks of the rational fraction ALU
// Watches the request and result channels; attached to the top by bind.
// ----------------------------------------------------------------------------
module rfa_check (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          o_req_ready,
    input rfa_pkg::t_req i_req,
    input logic          o_res_valid,
    input logic          i_res_ready,
    input rfa_pkg::t_rsp o_res
);

    // reset drops any pending result
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("stalled result changed");

    // one request in flight: ready drops after an accept
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request accepted while busy");

    // an error result carries nothing else
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.status == rfa_pkg::STAT_ERR) |->
            (o_res.result_num == '0) && (o_res.result_den == '0) &&
            (o_res.verdict == rfa_pkg::VERD_NONE))
        else $error("error result with nonzero fields");

endmodule

bind rational_fraction_alu rfa_check u_rfa_check (.*);

// ===== sim/rational_fraction_alu_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_fraction_alu_test: self-checking bench for the rational fraction ALU
// Drives directed corner requests, then random requests per operation class,
// under four sender/receiver idling patterns. Each result is checked, field by
// field, against an in-bench computation of the unreduced fraction result.
// ----------------------------------------------------------------------------
module rational_fraction_alu_test;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Wait kept after the last result; the longest path is unequal-denominator add/subtract.
    localparam int DRAIN_CYCLES = 200;

    // Operation class that a random request is drawn from.
    typedef enum int {
        MIX_PRODUCT,
        MIX_COMMON_DEN,
        MIX_COMPARE,
        MIX_UNARY,
        MIX_ANY
    } t_mix;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_req_valid = 1'b0;
    logic          o_req_ready;
    rfa_pkg::t_req i_req       = '0;
    logic          o_res_valid;
    logic          i_res_ready = 1'b1;
    rfa_pkg::t_rsp o_res;

    rfa_pkg::t_rsp pending_outcomes[$];   // predicted results, oldest first
    int    mismatch_count = 0;
    int    cycle_count    = 0;
    int    req_idle_pct   = 0;    // chance per cycle that the sender holds off
    int    res_stall_pct  = 0;    // chance per cycle that the receiver stalls

    rational_fraction_alu dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_outcomes.size());
            $display("FAIL rational_fraction_alu");
            $finish;
        end
    end

    // Receiver back-pressure: redraw ready at every falling edge.
    always @(negedge i_clk) begin
        i_res_ready <= ($urandom_range(99) >= res_stall_pct);
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Take the low OPERAND_BITS of a field as two's complement.
    function automatic longint operand_value(logic [rfa_pkg::FIELD_W-1:0] f);
        logic [63:0] w;
        w = 64'(f) << (64 - rfa_pkg::OPERAND_BITS);
        return $signed(w) >>> (64 - rfa_pkg::OPERAND_BITS);
    endfunction

    // Euclid with truncating remainder, so the result may come out negative.
    function automatic longint euclid_trunc(longint a, longint b);
        longint r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // a/b > c/d without division; flip the sense when exactly one
    // denominator is negative.
    function automatic bit frac_exceeds(longint a, longint b, longint c, longint d);
        longint lhs;
        longint rhs;
        lhs = a * d;
        rhs = c * b;
        if ((b < 0) != (d < 0))
            return lhs < rhs;
        return lhs > rhs;
    endfunction

    function automatic rfa_pkg::t_rsp fraction_outcome(rfa_pkg::t_req r);
        longint        x1, y1, x2, y2;
        longint        g, l, t1, t2;
        longint        rn, rd;
        logic [1:0]    verd;
        logic          stat;
        rfa_pkg::t_rsp o;
        x1   = operand_value(r.num_a);
        y1   = operand_value(r.den_a);
        x2   = operand_value(r.num_b);
        y2   = operand_value(r.den_b);
        rn   = 0;
        rd   = 0;
        verd = rfa_pkg::VERD_NONE;
        stat = rfa_pkg::STAT_OK;
        // Zero denominators, division by a zero fraction, inverting zero.
        if (r.cmd != rfa_pkg::CMD_RSVD &&
                (y1 == 0 || (r.cmd <= rfa_pkg::CMD_CMP && y2 == 0) ||
                 (r.cmd == rfa_pkg::CMD_DIV && x2 == 0) ||
                 (r.cmd == rfa_pkg::CMD_INV && x1 == 0)))
            stat = rfa_pkg::STAT_ERR;
        if (stat == rfa_pkg::STAT_OK) begin
            case (r.cmd)
                rfa_pkg::CMD_MUL: begin
                    rn = x1 * x2;
                    rd = y1 * y2;
                end
                rfa_pkg::CMD_DIV: begin
                    rn = x1 * y2;
                    rd = y1 * x2;
                end
                rfa_pkg::CMD_ADD, rfa_pkg::CMD_SUB: begin
                    if (y1 == y2) begin
                        // Shared denominator kept as given.
                        rn = (r.cmd == rfa_pkg::CMD_ADD) ? x1 + x2 : x1 - x2;
                        rd = y1;
                    end else begin
                        g  = euclid_trunc(y1, y2);
                        l  = (y1 * y2) / g;
                        t1 = (l / y1) * x1;
                        t2 = (l / y2) * x2;
                        rn = (r.cmd == rfa_pkg::CMD_ADD) ? t1 + t2 : t1 - t2;
                        rd = l;
                    end
                end
                rfa_pkg::CMD_CMP: begin
                    if (frac_exceeds(x1, y1, x2, y2)) begin
                        rn   = x1;
                        rd   = y1;
                        verd = rfa_pkg::VERD_FIRST;
                    end else if (frac_exceeds(x2, y2, x1, y1)) begin
                        rn   = x2;
                        rd   = y2;
                        verd = rfa_pkg::VERD_SECOND;
                    end else begin
                        rn   = x1;
                        rd   = y1;
                        verd = rfa_pkg::VERD_EQUAL;
                    end
                end
                rfa_pkg::CMD_INV: begin
                    rn = y1;
                    rd = x1;
                end
                rfa_pkg::CMD_CLS: begin
                    verd = ((x1 < 0 ? -x1 : x1) < (y1 < 0 ? -y1 : y1)) ?
                           rfa_pkg::VERD_PROPER : rfa_pkg::VERD_IMPROPER;
                end
                default: begin
                end
            endcase
        end
        o.result_num = rfa_pkg::NUM_W'(rn);
        o.result_den = rfa_pkg::DEN_W'(rd);
        o.verdict    = verd;
        o.status     = stat;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s, got 'h%0h, expected 'h%0h",
                 cycle_count, what, got, want);
    endtask

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        rfa_pkg::t_rsp want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result with no request pending",
                                64'(o_res.result_num), 64'd0);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_res.result_num !== want.result_num)
                    report_mismatch("result_num", 64'(o_res.result_num),
                                    64'(want.result_num));
                if (o_res.result_den !== want.result_den)
                    report_mismatch("result_den", 64'(o_res.result_den),
                                    64'(want.result_den));
                if (o_res.verdict !== want.verdict)
                    report_mismatch("verdict", 64'(o_res.verdict), 64'(want.verdict));
                if (o_res.status !== want.status)
                    report_mismatch("status", 64'(o_res.status), 64'(want.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Pattern 0: no idling; 1: sender idles; 2: receiver stalls; 3: both.
    task automatic set_idling(int pattern);
        case (pattern)
            1:       begin req_idle_pct = 73; res_stall_pct = 0;  end
            2:       begin req_idle_pct = 0;  res_stall_pct = 73; end
            3:       begin req_idle_pct = 24; res_stall_pct = 24; end
            default: begin req_idle_pct = 0;  res_stall_pct = 0;  end
        endcase
    endtask

    // Enter and leave at a falling edge. Valid is only dropped while idling,
    // so back-to-back requests keep it high.
    task automatic send_request(rfa_pkg::t_req r);
        while ($urandom_range(99) < req_idle_pct) begin
            i_req_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        pending_outcomes.push_back(fraction_outcome(r));
        @(negedge i_clk);
    endtask

    task automatic send_fields(logic [2:0] c, int na, int da, int nb, int db);
        rfa_pkg::t_req r;
        r.cmd   = c;
        r.num_a = rfa_pkg::FIELD_W'(na);
        r.den_a = rfa_pkg::FIELD_W'(da);
        r.num_b = rfa_pkg::FIELD_W'(nb);
        r.den_b = rfa_pkg::FIELD_W'(db);
        send_request(r);
    endtask

    // Corners, small values and full-range values, in rising order of weight.
    function automatic logic [rfa_pkg::FIELD_W-1:0] pick_operand();
        int roll;
        int s;
        roll = $urandom_range(99);
        if (roll < 20) begin
            case ($urandom_range(5))
                0:       return 16'h8000;
                1:       return 16'h7fff;
                2:       return 16'hffff;
                3:       return 16'h0000;
                4:       return 16'h0001;
                default: return 16'h8001;
            endcase
        end
        if (roll < 50) begin
            s = int'($urandom_range(40)) - 20;
            return rfa_pkg::FIELD_W'(s);
        end
        return rfa_pkg::FIELD_W'($urandom);
    endfunction

    // Denominators are zero only now and then.
    function automatic logic [rfa_pkg::FIELD_W-1:0] pick_den();
        logic [rfa_pkg::FIELD_W-1:0] v;
        v = pick_operand();
        while (v == 0 && $urandom_range(99) >= 4)
            v = pick_operand();
        return v;
    endfunction

    function automatic int small_signed(int lim);
        int s;
        s = int'($urandom_range(lim, 1));
        return $urandom_range(1) ? -s : s;
    endfunction

    function automatic rfa_pkg::t_req make_request(t_mix mix);
        rfa_pkg::t_req r;
        int            f, p, q, k, na, da;
        r.num_a = pick_operand();
        r.den_a = pick_den();
        r.num_b = pick_operand();
        r.den_b = pick_den();
        case (mix)
            MIX_PRODUCT: begin
                r.cmd = $urandom_range(1) ? rfa_pkg::CMD_DIV : rfa_pkg::CMD_MUL;
                // Scalar multiply: second fraction is m/m.
                if (r.cmd == rfa_pkg::CMD_MUL && $urandom_range(3) == 0)
                    r.den_b = r.num_b;
            end
            MIX_COMMON_DEN: begin
                r.cmd = $urandom_range(1) ? rfa_pkg::CMD_SUB : rfa_pkg::CMD_ADD;
                case ($urandom_range(3))
                    0: r.den_b = r.den_a;
                    1, 2: begin
                        // Shared factor gives a long Euclid chain and a real LCM.
                        f = int'($urandom_range(200, 1));
                        p = small_signed(150);
                        q = small_signed(150);
                        r.den_a = rfa_pkg::FIELD_W'(f * p);
                        r.den_b = rfa_pkg::FIELD_W'(f * q);
                    end
                    default: begin
                    end
                endcase
            end
            MIX_COMPARE: begin
                r.cmd = rfa_pkg::CMD_CMP;
                // Equal values written differently.
                if ($urandom_range(2) == 0) begin
                    na = int'($urandom_range(1200)) - 600;
                    da = small_signed(600);
                    k  = small_signed(50);
                    r.num_a = rfa_pkg::FIELD_W'(na);
                    r.den_a = rfa_pkg::FIELD_W'(da);
                    r.num_b = rfa_pkg::FIELD_W'(na * k);
                    r.den_b = rfa_pkg::FIELD_W'(da * k);
                end
            end
            MIX_UNARY: begin
                r.cmd = $urandom_range(1) ? rfa_pkg::CMD_CLS : rfa_pkg::CMD_INV;
                // Magnitudes equal: the proper/improper boundary.
                if ($urandom_range(4) == 0)
                    r.num_a = $urandom_range(1) ? r.den_a : -r.den_a;
            end
            default: begin
                r.cmd = ($urandom_range(99) == 0) ? rfa_pkg::CMD_RSVD
                                                  : 3'($urandom_range(6));
            end
        endcase
        return r;
    endfunction

    // Split the requests evenly over the four idling patterns.
    task automatic run_phase(t_mix mix, int count);
        for (int pattern = 0; pattern < 4; pattern++) begin
            set_idling(pattern);
            repeat (count / 4) send_request(make_request(mix));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_cases();
        set_idling(0);
        send_fields(rfa_pkg::CMD_MUL, 32767, -32768, -32768, 32767);
        send_fields(rfa_pkg::CMD_MUL, -32768, -32768, -32768, -32768);
        send_fields(rfa_pkg::CMD_MUL, 2, 3, 5, 5);            // scalar multiply
        send_fields(rfa_pkg::CMD_MUL, 0, -1, 0, -1);
        send_fields(rfa_pkg::CMD_DIV, 3, 4, 5, 7);
        send_fields(rfa_pkg::CMD_DIV, -32768, 32767, -1, -32768);
        send_fields(rfa_pkg::CMD_DIV, 3, 4, 0, 7);            // divide by zero fraction
        send_fields(rfa_pkg::CMD_ADD, 1, 6, 5, 6);            // equal denominators
        send_fields(rfa_pkg::CMD_SUB, -32768, 7, 32767, 7);
        send_fields(rfa_pkg::CMD_ADD, 1, 6, 1, -4);           // negative second denominator
        send_fields(rfa_pkg::CMD_SUB, -32768, 32767, 32767, -32768);
        send_fields(rfa_pkg::CMD_ADD, 7, 30030, -11, 24024);
        send_fields(rfa_pkg::CMD_CMP, 1, 2, 2, 4);            // equal values
        send_fields(rfa_pkg::CMD_CMP, 1, -2, -1, 3);
        send_fields(rfa_pkg::CMD_CMP, -3, 4, 1, 5);
        send_fields(rfa_pkg::CMD_CMP, 32767, -32768, -32768, 32767);
        send_fields(rfa_pkg::CMD_INV, 0, 5, 0, 0);            // invert zero
        send_fields(rfa_pkg::CMD_INV, -32768, 5, 1, 0);       // second denominator unused
        send_fields(rfa_pkg::CMD_CLS, 3, -3, 0, 0);
        send_fields(rfa_pkg::CMD_CLS, 2, -3, 0, 0);
        send_fields(rfa_pkg::CMD_CLS, -32768, 32767, 0, 0);
        send_fields(rfa_pkg::CMD_ADD, 1, 0, 1, 1);            // zero first denominator
        send_fields(rfa_pkg::CMD_MUL, 1, 1, 1, 0);            // zero second denominator
        send_fields(rfa_pkg::CMD_CLS, 5, 0, 5, 5);
        send_fields(rfa_pkg::CMD_RSVD, -1, -1, -1, -1);       // unused opcode
    endtask

    task automatic test_products();
        run_phase(MIX_PRODUCT, 300);
    endtask

    task automatic test_common_denominator();
        run_phase(MIX_COMMON_DEN, 500);
    endtask

    task automatic test_compare();
        run_phase(MIX_COMPARE, 300);
    endtask

    task automatic test_unary();
        run_phase(MIX_UNARY, 200);
    endtask

    task automatic test_mixed();
        run_phase(MIX_ANY, 300);
    endtask

    initial begin
        // Hold reset, then release at a falling edge.
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_products();
        test_common_denominator();
        test_compare();
        test_unary();
        test_mixed();

        // Drop valid, open the receiver and drain what is still in flight.
        i_req_valid <= 1'b0;
        set_idling(0);
        while (pending_outcomes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS rational_fraction_alu");
        end else begin
            $display("FAIL rational_fraction_alu");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rfa_pkg.sv
rtl/core/rational_fraction_alu.sv
rtl/core/rfa_check.sv
sim/rational_fraction_alu_test.sv
